@@ hw/rtl/dre_pkg.sv @@
`default_nettype none

package dre_pkg;

    // Parse phase, one-hot.
    typedef enum logic [10:0] {
        PH_HDR    = 11'b000_0000_0001,
        PH_QLEN   = 11'b000_0000_0010,
        PH_QLABEL = 11'b000_0000_0100,
        PH_QPTR   = 11'b000_0000_1000,
        PH_QFIX   = 11'b000_0001_0000,
        PH_ALEN   = 11'b000_0010_0000,
        PH_ALABEL = 11'b000_0100_0000,
        PH_APTR   = 11'b000_1000_0000,
        PH_AFIX   = 11'b001_0000_0000,
        PH_RDATA  = 11'b010_0000_0000,
        PH_DONE   = 11'b100_0000_0000
    } phase_t;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_MATCH  = 2'd1;
    localparam logic [1:0] ST_ERROR     = 2'd2;
    localparam logic [1:0] ST_NAME_LONG = 2'd3;

    localparam logic KIND_ADDR   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam logic [3:0]  HDR_BYTES      = 4'd12;
    localparam logic [3:0]  RR_FIXED_BYTES = 4'd10;
    localparam logic [3:0]  QFIX_BYTES     = 4'd4;
    localparam logic [15:0] TYPE_A         = 16'd1;
    localparam logic [15:0] A_RDATA_BYTES  = 16'd4;

    // Result queue depth; two free entries are needed to take a byte.
    localparam int RQ_DEPTH = 4;

    typedef struct packed {
        logic        kind;
        logic [31:0] address;
        logic [1:0]  status;
        logic [1:0]  found;
        logic        run_end;
    } result_t;

endpackage

`default_nettype wire

@@ hw/rtl/dre_parser.sv @@
`default_nettype none

module dre_parser #(
    parameter int MAX_ADDRESSES = 3,
    parameter int NAME_LIMIT    = 256
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              step,
    input  wire logic [7:0]        byte_in,
    input  wire logic              last_in,
    input  wire logic [15:0]       expected_id,
    output dre_pkg::result_t       addr_res,
    output logic                   addr_valid,
    output dre_pkg::result_t       stat_res,
    output logic                   stat_valid
);

    dre_pkg::phase_t phase_reg, phase_next;
    logic [3:0]  fbi_reg, fbi_next;
    logic [7:0]  id_hi_reg, id_hi_next;
    logic [15:0] qleft_reg, qleft_next;
    logic [15:0] aleft_reg, aleft_next;
    logic [5:0]  lbl_reg, lbl_next;
    logic [8:0]  nlen_reg, nlen_next;
    logic [15:0] rtype_reg, rtype_next;
    logic [15:0] rdleft_reg, rdleft_next;
    logic [23:0] acol_reg, acol_next;
    logic [1:0]  found_reg, found_next;
    logic [1:0]  outcome_reg, outcome_next;

    logic        is_answer;
    logic [5:0]  label_len;
    logic [9:0]  name_sum;
    logic [15:0] aleft_dec;
    logic [15:0] rdleft_dec;
    logic        stop;

    assign is_answer  = (phase_reg == dre_pkg::PH_ALEN);
    assign label_len  = byte_in[5:0];
    assign name_sum   = {1'b0, nlen_reg} + {4'd0, label_len} + 10'd1;
    assign aleft_dec  = aleft_reg - 16'd1;
    assign rdleft_dec = rdleft_reg - 16'd1;

    always_comb
    begin
        phase_next   = phase_reg;
        fbi_next     = fbi_reg;
        id_hi_next   = id_hi_reg;
        qleft_next   = qleft_reg;
        aleft_next   = aleft_reg;
        lbl_next     = lbl_reg;
        nlen_next    = nlen_reg;
        rtype_next   = rtype_reg;
        rdleft_next  = rdleft_reg;
        acol_next    = acol_reg;
        found_next   = found_reg;
        outcome_next = outcome_reg;
        stop         = 1'b0;
        addr_valid   = 1'b0;
        stat_valid   = 1'b0;
        addr_res     = '0;
        stat_res     = '0;

        case (phase_reg)
            dre_pkg::PH_HDR:
            begin
                case (fbi_reg)
                    4'd0: id_hi_next = byte_in;
                    4'd1:
                    begin
                        if ({id_hi_reg, byte_in} != expected_id)
                        begin
                            outcome_next = dre_pkg::ST_NO_MATCH;
                            phase_next   = dre_pkg::PH_DONE;
                        end
                    end
                    4'd2:
                    begin
                        if (!byte_in[7])
                        begin
                            outcome_next = dre_pkg::ST_NO_MATCH;
                            phase_next   = dre_pkg::PH_DONE;
                        end
                    end
                    4'd3:
                    begin
                        if (byte_in[3:0] != 4'd0)
                        begin
                            outcome_next = dre_pkg::ST_ERROR;
                            phase_next   = dre_pkg::PH_DONE;
                        end
                    end
                    4'd4: qleft_next = {byte_in, 8'd0};
                    4'd5: qleft_next = {qleft_reg[15:8], byte_in};
                    4'd6: aleft_next = {byte_in, 8'd0};
                    4'd7:
                    begin
                        aleft_next = {aleft_reg[15:8], byte_in};
                        if ({aleft_reg[15:8], byte_in} == 16'd0)
                        begin
                            outcome_next = dre_pkg::ST_ERROR;
                            phase_next   = dre_pkg::PH_DONE;
                        end
                    end
                    default: ;
                endcase
                if (phase_next == dre_pkg::PH_HDR)
                begin
                    if (fbi_reg == dre_pkg::HDR_BYTES - 4'd1)
                    begin
                        fbi_next = 4'd0;
                        if (qleft_next != 16'd0)
                            phase_next = dre_pkg::PH_QLEN;
                        else
                        begin
                            nlen_next  = 9'd0;
                            phase_next = dre_pkg::PH_ALEN;
                        end
                    end
                    else
                        fbi_next = fbi_reg + 4'd1;
                end
            end
            dre_pkg::PH_QLEN, dre_pkg::PH_ALEN:
            begin
                if (byte_in == 8'd0)
                begin
                    fbi_next   = 4'd0;
                    phase_next = is_answer ? dre_pkg::PH_AFIX : dre_pkg::PH_QFIX;
                end
                else if (byte_in[7:6] == 2'b11)
                    phase_next = is_answer ? dre_pkg::PH_APTR : dre_pkg::PH_QPTR;
                else if (is_answer && (name_sum >= 10'(NAME_LIMIT)))
                begin
                    outcome_next = dre_pkg::ST_NAME_LONG;
                    phase_next   = dre_pkg::PH_DONE;
                end
                else
                begin
                    if (is_answer)
                        nlen_next = name_sum[8:0];
                    lbl_next = label_len;
                    if (label_len != 6'd0)
                        phase_next = is_answer ? dre_pkg::PH_ALABEL : dre_pkg::PH_QLABEL;
                end
            end
            dre_pkg::PH_QLABEL, dre_pkg::PH_ALABEL:
            begin
                lbl_next = lbl_reg - 6'd1;
                if (lbl_reg == 6'd1)
                    phase_next = (phase_reg == dre_pkg::PH_QLABEL) ?
                                 dre_pkg::PH_QLEN : dre_pkg::PH_ALEN;
            end
            dre_pkg::PH_QPTR:
            begin
                fbi_next   = 4'd0;
                phase_next = dre_pkg::PH_QFIX;
            end
            dre_pkg::PH_APTR:
            begin
                fbi_next   = 4'd0;
                phase_next = dre_pkg::PH_AFIX;
            end
            dre_pkg::PH_QFIX:
            begin
                if (fbi_reg == dre_pkg::QFIX_BYTES - 4'd1)
                begin
                    fbi_next   = 4'd0;
                    qleft_next = qleft_reg - 16'd1;
                    if (qleft_reg == 16'd1)
                    begin
                        nlen_next  = 9'd0;
                        phase_next = dre_pkg::PH_ALEN;
                    end
                    else
                        phase_next = dre_pkg::PH_QLEN;
                end
                else
                    fbi_next = fbi_reg + 4'd1;
            end
            dre_pkg::PH_AFIX:
            begin
                case (fbi_reg)
                    4'd0: rtype_next  = {byte_in, 8'd0};
                    4'd1: rtype_next  = {rtype_reg[15:8], byte_in};
                    4'd8: rdleft_next = {byte_in, 8'd0};
                    4'd9: rdleft_next = {rdleft_reg[15:8], byte_in};
                    default: ;
                endcase
                if (fbi_reg == dre_pkg::RR_FIXED_BYTES - 4'd1)
                begin
                    acol_next = 24'd0;
                    // Records that cannot carry a full address skip collection.
                    fbi_next  = ((rtype_reg == dre_pkg::TYPE_A) &&
                                 (rdleft_next >= dre_pkg::A_RDATA_BYTES)) ? 4'd0 : 4'd4;
                    if (rdleft_next == 16'd0)
                    begin
                        aleft_next = aleft_dec;
                        if (aleft_dec == 16'd0)
                            phase_next = dre_pkg::PH_DONE;
                        else
                        begin
                            nlen_next  = 9'd0;
                            phase_next = dre_pkg::PH_ALEN;
                        end
                    end
                    else
                        phase_next = dre_pkg::PH_RDATA;
                end
                else
                    fbi_next = fbi_reg + 4'd1;
            end
            dre_pkg::PH_RDATA:
            begin
                rdleft_next = rdleft_dec;
                if (fbi_reg[3:2] == 2'b00)
                begin
                    acol_next = {acol_reg[15:0], byte_in};
                    fbi_next  = fbi_reg + 4'd1;
                    if (fbi_reg == 4'd3)
                    begin
                        found_next       = found_reg + 2'd1;
                        addr_valid       = 1'b1;
                        addr_res.kind    = dre_pkg::KIND_ADDR;
                        addr_res.address = {acol_reg, byte_in};
                        addr_res.status  = dre_pkg::ST_OK;
                        addr_res.found   = found_reg + 2'd1;
                        addr_res.run_end = !last_in;
                        if ((found_reg + 2'd1) >= 2'(MAX_ADDRESSES))
                        begin
                            phase_next = dre_pkg::PH_DONE;
                            stop       = 1'b1;
                        end
                    end
                end
                if (!stop && (rdleft_dec == 16'd0))
                begin
                    aleft_next = aleft_dec;
                    if (aleft_dec == 16'd0)
                        phase_next = dre_pkg::PH_DONE;
                    else
                    begin
                        nlen_next  = 9'd0;
                        phase_next = dre_pkg::PH_ALEN;
                    end
                end
            end
            default: ;
        endcase

        if (last_in)
        begin
            stat_valid       = 1'b1;
            stat_res.kind    = dre_pkg::KIND_STATUS;
            stat_res.address = 32'd0;
            // A packet that ends inside the header never matched.
            stat_res.status  = ((phase_next == dre_pkg::PH_HDR) &&
                                (outcome_next == dre_pkg::ST_OK)) ?
                               dre_pkg::ST_NO_MATCH : outcome_next;
            stat_res.found   = found_next;
            stat_res.run_end = 1'b1;

            phase_next   = dre_pkg::PH_HDR;
            fbi_next     = 4'd0;
            id_hi_next   = 8'd0;
            qleft_next   = 16'd0;
            aleft_next   = 16'd0;
            lbl_next     = 6'd0;
            nlen_next    = 9'd0;
            rtype_next   = 16'd0;
            rdleft_next  = 16'd0;
            acol_next    = 24'd0;
            found_next   = 2'd0;
            outcome_next = dre_pkg::ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= dre_pkg::PH_HDR;
            fbi_reg     <= 4'd0;
            id_hi_reg   <= 8'd0;
            qleft_reg   <= 16'd0;
            aleft_reg   <= 16'd0;
            lbl_reg     <= 6'd0;
            nlen_reg    <= 9'd0;
            rtype_reg   <= 16'd0;
            rdleft_reg  <= 16'd0;
            acol_reg    <= 24'd0;
            found_reg   <= 2'd0;
            outcome_reg <= dre_pkg::ST_OK;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            fbi_reg     <= fbi_next;
            id_hi_reg   <= id_hi_next;
            qleft_reg   <= qleft_next;
            aleft_reg   <= aleft_next;
            lbl_reg     <= lbl_next;
            nlen_reg    <= nlen_next;
            rtype_reg   <= rtype_next;
            rdleft_reg  <= rdleft_next;
            acol_reg    <= acol_next;
            found_reg   <= found_next;
            outcome_reg <= outcome_next;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/dre_result_queue.sv @@
`default_nettype none

module dre_result_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              wr0,
    input  wire dre_pkg::result_t  wdata0,
    input  wire logic              wr1,
    input  wire dre_pkg::result_t  wdata1,
    output logic                   room2,
    output logic                   rd_valid,
    output dre_pkg::result_t       rd_data,
    input  wire logic              rd_ready
);

    localparam int PW = $clog2(dre_pkg::RQ_DEPTH);
    localparam int CW = $clog2(dre_pkg::RQ_DEPTH + 1);

    dre_pkg::result_t mem [dre_pkg::RQ_DEPTH];

    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic [PW-1:0] slot1;
    logic          pop;

    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem[rd_ptr_reg];
    assign pop      = rd_valid && rd_ready;
    assign room2    = (count_reg <= CW'(dre_pkg::RQ_DEPTH - 2));
    // The second result of a byte goes behind the first one if there is one.
    assign slot1    = wr_ptr_reg + PW'(wr0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PW'(wr0) + PW'(wr1);
        rd_ptr_next = rd_ptr_reg + PW'(pop);
        count_next  = count_reg + CW'(wr0) + CW'(wr1) - CW'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (wr0)
            mem[wr_ptr_reg] <= wdata0;
        if (wr1)
            mem[slot1] <= wdata1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/dns_response_address_extractor.sv @@
// A result can be taken on the output in the cycle after its byte is accepted.
// Throughput: one byte per cycle; input is held off while fewer than two queue entries
// are free. The parse state advances on each accepted beat. A byte may cause two
// results, which drain one per accepted output beat through a four-entry result queue.
// Reset (rst_n low, asynchronous) returns the parser to the header phase, empties the
// queue and clears expected_id to zero.
`default_nettype none

module dns_response_address_extractor #(
    parameter int MAX_ADDRESSES = 3,
    parameter int NAME_LIMIT    = 256
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_wdata,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] packet_byte
    input  wire logic        s_axis_tlast,   // end_of_packet
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,   // [31:0] address, [33:32] status,
                                             // [35:34] found, [39:36] zero
    output logic [0:0]       m_axis_tuser,   // [0] kind
    output logic             m_axis_tlast    // run_end
);

    logic [15:0]      expected_id_reg;
    logic             step;
    dre_pkg::result_t addr_res;
    dre_pkg::result_t stat_res;
    dre_pkg::result_t out_res;
    logic             addr_valid;
    logic             stat_valid;
    logic             room2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            expected_id_reg <= 16'd0;
        else if (cfg_we)
            expected_id_reg <= cfg_wdata;
    end

    assign s_axis_tready = room2;
    assign step          = s_axis_tvalid && s_axis_tready;

    dre_parser #(
        .MAX_ADDRESSES (MAX_ADDRESSES),
        .NAME_LIMIT    (NAME_LIMIT)
    ) u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .byte_in     (s_axis_tdata),
        .last_in     (s_axis_tlast),
        .expected_id (expected_id_reg),
        .addr_res    (addr_res),
        .addr_valid  (addr_valid),
        .stat_res    (stat_res),
        .stat_valid  (stat_valid)
    );

    dre_result_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr0      (step && addr_valid),
        .wdata0   (addr_res),
        .wr1      (step && stat_valid),
        .wdata1   (stat_res),
        .room2    (room2),
        .rd_valid (m_axis_tvalid),
        .rd_data  (out_res),
        .rd_ready (m_axis_tready)
    );

    assign m_axis_tdata = {4'd0, out_res.found, out_res.status, out_res.address};
    assign m_axis_tuser = out_res.kind;
    assign m_axis_tlast = out_res.run_end;

    // A status beat always closes the run of results for its byte.
    a_status_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser[0] == dre_pkg::KIND_STATUS)) |-> m_axis_tlast)
        else $error("status beat without tlast");

    // An emitted address always counts itself.
    a_addr_counted: assert property (@(posedge clk) disable iff (!rst_n)
        (step && addr_valid) |-> (addr_res.found != 2'd0))
        else $error("address result with zero found count");

    // An address followed by end of packet must not be marked as run end.
    a_addr_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        (step && addr_valid && stat_valid) |-> !addr_res.run_end)
        else $error("address marked last although a status follows");

    // The end of a packet always produces a status result.
    a_eop_status: assert property (@(posedge clk) disable iff (!rst_n)
        (step && s_axis_tlast) |-> stat_valid)
        else $error("end of packet without status");

endmodule

`default_nettype wire
